### hw/rtl/ght_pkg.sv
package ght_pkg;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_LOOKUP  = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_RSVD     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_READ,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [1:0]         op;
        logic [63:0]        handle;
        logic [3:0]         kind;
        logic signed [31:0] descriptor;
        logic signed [31:0] wake_fd;
        logic [63:0]        base_address;
        logic [63:0]        exec_address;
        logic [63:0]        region_size;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [63:0]        result_handle;
        logic signed [31:0] found_descriptor;
        logic signed [31:0] found_wake_fd;
        logic [63:0]        found_address;
        logic [63:0]        found_exec_address;
        logic [63:0]        found_size;
    } t_rsp;

    // Payload row held in the data memory.
    typedef struct packed {
        logic [31:0] descriptor;
        logic [31:0] wake_fd;
        logic [63:0] base_address;
        logic [63:0] exec_address;
        logic [63:0] region_size;
    } t_row;

    localparam int GEN_W = 32;

endpackage

### hw/rtl/generational_handle_table_unit.sv
// Generational handle table.
// Steps: request latched at start, then S_SEARCH, S_READ, S_EXEC; done registered.
// A new transaction is taken only in S_IDLE; busy covers the search/read/update.
// The tag memory read then the read-modify-write sets the pace.
// Reset: synchronous active low; all slots free, generations zero, no clearing pass.
// The receiver cannot stall: o_done pulses one cycle with the result.
module generational_handle_table_unit #(
    parameter int SLOTS = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ght_pkg::t_req i_req,
    output logic          o_done,
    output ght_pkg::t_rsp o_rsp
);
    import ght_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_state        r_state, n_state;
    t_req          r_req;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_ok, n_ok;
    logic          r_done;
    t_rsp          r_rsp, n_rsp;

    logic          w_any;
    logic [IW-1:0] w_first;
    logic [35:0]   w_tag;
    t_row          w_row;
    logic [31:0]   w_lowpart;
    logic [31:0]   w_newgen;
    logic          w_twe, w_dwe, w_set, w_clr;
    logic [35:0]   w_wtag;
    t_row          w_wrow;

    assign w_lowpart = r_req.handle[31:0];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (start) n_state = S_SEARCH;
            S_SEARCH: n_state = S_READ;
            S_READ:   n_state = S_EXEC;
            S_EXEC:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Index decode; free bitmap result is settled by S_SEARCH.
    always_comb begin
        n_idx = r_idx;
        n_ok  = r_ok;
        if (r_state == S_SEARCH) begin
            if (r_req.op == OP_ALLOC) begin
                n_idx = w_first;
                n_ok  = w_any;
            end else begin
                n_idx = IW'(w_lowpart - 32'd1);
                n_ok  = (w_lowpart != 32'd0) && ((w_lowpart - 32'd1) < 32'(SLOTS));
            end
        end
    end

    // Execute: tag is read out in S_EXEC.
    always_comb begin
        w_newgen = w_tag[31:0] + 32'd1;
        if (w_newgen == 32'd0) w_newgen = 32'd1;
        w_twe  = 1'b0;
        w_dwe  = 1'b0;
        w_set  = 1'b0;
        w_clr  = 1'b0;
        w_wtag = w_tag;
        w_wrow = w_row;
        n_rsp  = '0;
        n_rsp.status = ST_NOTFOUND;
        if (r_state == S_EXEC && r_req.kind != 4'd0) begin
            case (r_req.op)
                OP_ALLOC: begin
                    if (!r_ok) begin
                        n_rsp.status = ST_FULL;
                    end else begin
                        w_twe  = 1'b1;
                        w_dwe  = 1'b1;
                        w_set  = 1'b1;
                        w_wtag = {r_req.kind, w_newgen};
                        w_wrow = {r_req.descriptor, r_req.wake_fd,
                                  r_req.base_address, r_req.exec_address,
                                  r_req.region_size};
                        n_rsp.status        = ST_OK;
                        n_rsp.result_handle = {w_newgen, 32'(r_idx) + 32'd1};
                    end
                end
                OP_LOOKUP, OP_RELEASE: begin
                    if (r_ok && w_tag[31:0] == r_req.handle[63:32]
                        && w_tag[35:32] == r_req.kind) begin
                        n_rsp.status        = ST_OK;
                        n_rsp.result_handle = r_req.handle;
                        if (r_req.op == OP_LOOKUP) begin
                            n_rsp.found_descriptor   = w_row.descriptor;
                            n_rsp.found_wake_fd      = w_row.wake_fd;
                            n_rsp.found_address      = w_row.base_address;
                            n_rsp.found_exec_address = w_row.exec_address;
                            n_rsp.found_size         = w_row.region_size;
                        end else begin
                            w_twe  = 1'b1;
                            w_dwe  = 1'b1;
                            w_clr  = 1'b1;
                            w_wtag = {4'd0, w_tag[31:0]};
                            w_wrow = {w_row.descriptor, w_row.wake_fd,
                                      64'd0, 64'd0, 64'd0};
                        end
                    end
                end
                default: n_rsp.status = ST_NOTFOUND;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_EXEC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_req <= i_req;
        end
        r_idx <= n_idx;
        r_ok  <= n_ok;
        if (r_state == S_EXEC) begin
            r_rsp <= n_rsp;
        end
    end

    // Outputs
    always_comb begin
        busy   = (r_state != S_IDLE);
        o_done = r_done;
        o_rsp  = r_rsp;
    end

    ght_free_map #(.SLOTS(SLOTS), .IW(IW)) u_free (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_set   (w_set),
        .i_clr   (w_clr),
        .i_idx   (r_idx),
        .o_any   (w_any),
        .o_first (w_first)
    );

    ght_slot_mem #(.SLOTS(SLOTS), .IW(IW)) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_raddr (r_idx),
        .i_twe   (w_twe),
        .i_waddr (r_idx),
        .i_tag   (w_wtag),
        .i_dwe   (w_dwe),
        .i_row   (w_wrow),
        .o_tag   (w_tag),
        .o_row   (w_row)
    );

    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) == S_EXEC)
        else $error("done without execute");
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_twe |-> r_state == S_EXEC)
        else $error("write outside execute");
    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == ST_OK) |-> o_rsp.result_handle[31:0] != 32'd0)
        else $error("ok with null handle");
endmodule

### hw/rtl/ght_free_map.sv
// Free-slot bitmap with a lowest-set-bit search, registered result.
module ght_free_map #(
    parameter int SLOTS = 256,
    parameter int IW    = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_set,
    input  logic          i_clr,
    input  logic [IW-1:0] i_idx,
    output logic          o_any,
    output logic [IW-1:0] o_first
);
    logic [SLOTS-1:0] r_used;
    logic [SLOTS-1:0] n_used;
    logic [SLOTS-1:0] w_free;
    logic [SLOTS-1:0] w_low;
    logic [IW-1:0]    w_enc;
    logic             r_any;
    logic [IW-1:0]    r_first;

    always_comb begin
        n_used = r_used;
        if (i_set) begin
            n_used[i_idx] = 1'b1;
        end
        if (i_clr) begin
            n_used[i_idx] = 1'b0;
        end
    end

    // Isolate lowest free bit, then OR-encode its position.
    assign w_free = ~r_used;
    assign w_low  = w_free & (~w_free + {{(SLOTS-1){1'b0}}, 1'b1});

    always_comb begin
        w_enc = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (w_low[i]) begin
                w_enc = w_enc | IW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_any   <= 1'b1;
            r_first <= '0;
        end else begin
            r_used  <= n_used;
            r_any   <= |w_free;
            r_first <= w_enc;
        end
    end

    assign o_any   = r_any;
    assign o_first = r_first;
endmodule

### hw/rtl/ght_slot_mem.sv
// Slot memories: tag (kind+generation) with per-slot valid bits, payload rows.
module ght_slot_mem #(
    parameter int SLOTS = 256,
    parameter int IW    = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [IW-1:0] i_raddr,
    input  logic          i_twe,
    input  logic [IW-1:0] i_waddr,
    input  logic [35:0]   i_tag,
    input  logic          i_dwe,
    input  ght_pkg::t_row i_row,
    output logic [35:0]   o_tag,
    output ght_pkg::t_row o_row
);
    import ght_pkg::*;

    logic [35:0]      r_tag_mem [SLOTS];
    t_row             r_row_mem [SLOTS];
    logic [SLOTS-1:0] r_written;
    logic [35:0]      r_tag_q;
    logic             r_vld_q;
    t_row             r_row_q;

    always_ff @(posedge i_clk) begin
        if (i_twe) begin
            r_tag_mem[i_waddr] <= i_tag;
        end
        if (i_dwe) begin
            r_row_mem[i_waddr] <= i_row;
        end
        r_tag_q <= r_tag_mem[i_raddr];
        r_row_q <= r_row_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_vld_q   <= 1'b0;
        end else begin
            if (i_twe) begin
                r_written[i_waddr] <= 1'b1;
            end
            r_vld_q <= r_written[i_raddr];
        end
    end

    assign o_tag = r_vld_q ? r_tag_q : '0;
    assign o_row = r_row_q;
endmodule
